// File: design/lzw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lzw_pkg;

   localparam int START_CODE_WIDTH = 9;
   localparam int MAX_CODE_WIDTH   = 12;
   localparam int STACK_DEPTH      = 4096;
   localparam int TABLE_SIZE       = 1 << MAX_CODE_WIDTH;
   localparam int CODE_BITS        = MAX_CODE_WIDTH;
   localparam int SLOT_BITS        = MAX_CODE_WIDTH + 1;
   localparam int FILL_BITS        = $clog2(STACK_DEPTH) + 1;
   localparam int SP_BITS          = $clog2(STACK_DEPTH);
   localparam int CW_BITS          = $clog2(MAX_CODE_WIDTH + 1);
   localparam int BUF_BITS         = MAX_CODE_WIDTH + 8;
   localparam int BCNT_BITS        = $clog2(BUF_BITS + 1);

   localparam logic [CODE_BITS-1:0] CODE_CLEAR = CODE_BITS'(256);
   localparam logic [CODE_BITS-1:0] CODE_END   = CODE_BITS'(257);
   localparam logic [SLOT_BITS-1:0] FIRST_SLOT = SLOT_BITS'(258);

   localparam logic [1:0] MODE_FEED  = 2'd0;
   localparam logic [1:0] MODE_PULL  = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_REJECT   = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_valid;
      logic [12:0] pending_count;
      logic        stream_done;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_PULL,
      CMD_START,
      CMD_BAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   in_byte;
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_DECODE,
      S_WALK_RD,
      S_WALK,
      S_LAST,
      S_UPDATE,
      S_POP_RD,
      S_POP,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

// File: design/lzw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Classifies requests into commands and holds them in a two-entry queue.
module lzw_front import lzw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         cmd_valid,
   output cmd_type      cmd_data,
   input  wire logic    cmd_take
);
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   cmd_type    c;
   logic       do_push, do_pop;

   always_comb begin
      c.in_byte = req_data.in_byte;
      unique case (req_data.mode)
         MODE_FEED:  c.kind = CMD_BYTE;
         MODE_PULL:  c.kind = CMD_PULL;
         MODE_START: c.kind = CMD_START;
         default:    c.kind = CMD_BAD;
      endcase
   end

   assign full      = cnt_ff[1];
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd_data  = q_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
      rd_in  = rd_ff ^ do_pop;
      wr_in  = wr_ff ^ do_push;
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ff] <= c;
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end
endmodule
`default_nettype wire

// File: design/lzw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Executes commands: code unpacking, chain walk, dictionary update and stack pops.
module lzw_back import lzw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_data,
   output logic         cmd_take,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);
   logic [CODE_BITS-1:0] prefix_mem [TABLE_SIZE];
   logic [7:0]           suffix_mem [TABLE_SIZE];
   logic [7:0]           stack_mem  [STACK_DEPTH];
   // Dictionary slots are written in order from the first free code, so every
   // written entry lies below this high-water mark; entries at or above it read as zero.
   logic [SLOT_BITS-1:0] hwm_ff, hwm_in;

   state_type state_ff, state_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic [BUF_BITS-1:0]  buf_ff, buf_in;
   logic [BCNT_BITS-1:0] bcnt_ff, bcnt_in;
   logic [CW_BITS-1:0]   cw_ff, cw_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [8:0]           pfb_ff, pfb_in;
   logic [CODE_BITS-1:0] last_ff, last_in;
   logic                 ac_ff, ac_in, done_ff, done_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic [CODE_BITS-1:0] c_ff, c_in;
   logic [1:0]           st_ff, st_in;
   rsp_type              out_ff, out_in;
   logic                 full_ff, full_in;

   logic [CODE_BITS-1:0] rd_addr;
   logic [CODE_BITS-1:0] pre_rd_ff;
   logic [7:0]           suf_rd_ff;
   logic                 tv_rd_ff;
   logic [7:0]           stk_rd_ff;
   logic                 tbl_we, stk_we;
   logic [CODE_BITS-1:0] tbl_wa;
   logic [CODE_BITS-1:0] tbl_wp;
   logic [7:0]           tbl_ws, stk_wd;
   logic [SP_BITS-1:0]   stk_wa, stk_ra;

   logic [BUF_BITS-1:0]  merged;
   logic [BCNT_BITS-1:0] cnt8;
   logic [CODE_BITS-1:0] mask, new_code;
   logic [SLOT_BITS-1:0] top;
   logic                 stack_full;
   logic [CODE_BITS-1:0] t_pre;
   logic [7:0]           t_suf;

   assign empty    = !full_ff;
   assign rsp_data = out_ff;
   assign stack_full = fill_ff >= FILL_BITS'(STACK_DEPTH);
   assign top      = SLOT_BITS'(1) << cw_ff;
   assign t_pre    = tv_rd_ff ? pre_rd_ff : '0;
   assign t_suf    = tv_rd_ff ? suf_rd_ff : '0;

   always_ff @(posedge clock) begin
      pre_rd_ff <= prefix_mem[rd_addr];
      suf_rd_ff <= suffix_mem[rd_addr];
      tv_rd_ff  <= {1'b0, rd_addr} < hwm_ff;
      stk_rd_ff <= stack_mem[stk_ra];
      if (tbl_we) begin
         prefix_mem[tbl_wa] <= tbl_wp;
         suffix_mem[tbl_wa] <= tbl_ws;
      end
      if (stk_we) stack_mem[stk_wa] <= stk_wd;
   end

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff; buf_in = buf_ff; bcnt_in = bcnt_ff; cw_in = cw_ff;
      slot_in = slot_ff; pfb_in = pfb_ff; last_in = last_ff; ac_in = ac_ff;
      done_in = done_ff; code_in = code_ff; c_in = c_ff; st_in = st_ff;
      out_in = out_ff; full_in = full_ff; hwm_in = hwm_ff;
      cmd_take = 1'b0;
      rd_addr = c_ff; tbl_we = 1'b0; tbl_wa = slot_ff[CODE_BITS-1:0];
      tbl_wp = last_ff; tbl_ws = c_ff[7:0];
      stk_we = 1'b0; stk_wa = fill_ff[SP_BITS-1:0]; stk_wd = '0;
      stk_ra = SP_BITS'(fill_ff - FILL_BITS'(1));
      merged = buf_ff | (BUF_BITS'(cmd_data.in_byte) << bcnt_ff);
      cnt8 = bcnt_ff + BCNT_BITS'(8);
      mask = CODE_BITS'((SLOT_BITS'(1) << cw_ff) - SLOT_BITS'(1));
      new_code = merged[CODE_BITS-1:0] & mask;
      if (pop && full_ff) full_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && (!full_ff || pop)) begin
               cmd_take = 1'b1;
               st_in = ST_OK;
               unique case (cmd_data.kind)
                  CMD_BYTE: begin
                     if (fill_ff != '0 || done_ff) begin
                        st_in = ST_REJECT; state_in = S_RESP;
                     end else begin
                        buf_in = merged; bcnt_in = cnt8; state_in = S_RESP;
                        if (cnt8 >= BCNT_BITS'(cw_ff)) begin
                           code_in = new_code;
                           buf_in = merged >> cw_ff;
                           bcnt_in = cnt8 - BCNT_BITS'(cw_ff);
                           state_in = S_DECODE;
                        end
                     end
                  end
                  CMD_PULL: begin
                     if (fill_ff == '0) begin
                        st_in = ST_REJECT; state_in = S_RESP;
                     end else state_in = S_POP_RD;
                  end
                  CMD_START: begin
                     hwm_in = FIRST_SLOT;
                     fill_in = '0; buf_in = '0; bcnt_in = '0;
                     cw_in = CW_BITS'(START_CODE_WIDTH); slot_in = FIRST_SLOT;
                     pfb_in = '0; last_in = '0; ac_in = 1'b0; done_in = 1'b0;
                     state_in = S_RESP;
                  end
                  default: begin
                     st_in = ST_REJECT; state_in = S_RESP;
                  end
               endcase
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            if (ac_ff) begin
               if (code_ff != CODE_CLEAR) begin
                  ac_in = 1'b0;
                  if (code_ff == CODE_END) done_in = 1'b0 | 1'b1;
                  else begin
                     c_in = ({1'b0, code_ff} >= FIRST_SLOT) ? '0 : code_ff;
                     pfb_in = 9'(c_in); last_in = c_in;
                     stk_we = 1'b1; stk_wd = c_in[7:0];
                     fill_in = fill_ff + FILL_BITS'(1);
                  end
               end
            end else if (code_ff == CODE_END) done_in = 1'b1;
            else if (code_ff == CODE_CLEAR) begin
               slot_in = FIRST_SLOT; cw_in = CW_BITS'(START_CODE_WIDTH); ac_in = 1'b1;
            end else begin
               c_in = code_ff;
               if ({1'b0, code_ff} >= slot_ff) begin
                  c_in = last_ff;
                  stk_we = 1'b1; stk_wd = pfb_ff[7:0];
                  fill_in = fill_ff + FILL_BITS'(1);
               end
               state_in = S_WALK_RD;
               if ({1'b0, code_ff} >= slot_ff && stack_full) begin
                  st_in = ST_OVERFLOW; stk_we = 1'b0; fill_in = fill_ff;
                  state_in = S_UPDATE;
               end
            end
         end
         S_WALK_RD: begin
            state_in = ({1'b0, c_ff} >= FIRST_SLOT) ? S_WALK : S_LAST;
         end
         S_WALK: begin
            if (stack_full) begin
               st_in = ST_OVERFLOW; state_in = S_UPDATE;
            end else begin
               stk_we = 1'b1; stk_wd = t_suf;
               fill_in = fill_ff + FILL_BITS'(1);
               c_in = t_pre; rd_addr = t_pre; state_in = S_WALK_RD;
            end
         end
         S_LAST: begin
            if (stack_full) st_in = ST_OVERFLOW;
            else begin
               stk_we = 1'b1; stk_wd = c_ff[7:0];
               fill_in = fill_ff + FILL_BITS'(1);
            end
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (slot_ff < top && slot_ff < SLOT_BITS'(TABLE_SIZE)) begin
               tbl_we = 1'b1;
               pfb_in = 9'(c_ff & CODE_BITS'(9'h1FF));
               last_in = code_ff;
               slot_in = slot_ff + SLOT_BITS'(1);
               if (slot_in > hwm_ff) hwm_in = slot_in;
               if (slot_in >= top && cw_ff < CW_BITS'(MAX_CODE_WIDTH))
                  cw_in = cw_ff + CW_BITS'(1);
            end else if (cw_ff < CW_BITS'(MAX_CODE_WIDTH)) cw_in = cw_ff + CW_BITS'(1);
            state_in = S_RESP;
         end
         S_POP_RD: state_in = S_POP;
         S_POP: begin
            fill_in = fill_ff - FILL_BITS'(1);
            out_in.out_byte = stk_rd_ff; out_in.out_valid = 1'b1;
            out_in.pending_count = 13'(fill_in); out_in.stream_done = done_ff;
            out_in.status = ST_OK;
            if (!full_ff || pop) begin full_in = 1'b1; state_in = S_IDLE; end
            else begin fill_in = fill_ff; out_in = out_ff; end
         end
         S_RESP: begin
            if (!full_ff || pop) begin
               out_in.out_byte = '0; out_in.out_valid = 1'b0;
               out_in.pending_count = 13'(fill_ff);
               out_in.stream_done = done_ff; out_in.status = st_ff;
               full_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in; code_ff <= code_in; c_ff <= c_in; st_ff <= st_in;
      if (reset) begin
         state_ff <= S_IDLE; full_ff <= 1'b0; fill_ff <= '0;
         cw_ff <= CW_BITS'(START_CODE_WIDTH); slot_ff <= FIRST_SLOT;
         ac_ff <= 1'b0; done_ff <= 1'b0; hwm_ff <= FIRST_SLOT;
         buf_ff <= '0; bcnt_ff <= '0; pfb_ff <= '0; last_ff <= '0;
      end else begin
         state_ff <= state_in; full_ff <= full_in; fill_ff <= fill_in;
         cw_ff <= cw_in; slot_ff <= slot_in; ac_ff <= ac_in; done_ff <= done_in;
         hwm_ff <= hwm_in;
         buf_ff <= buf_in; bcnt_ff <= bcnt_in; pfb_ff <= pfb_in; last_ff <= last_in;
      end
   end
endmodule
`default_nettype wire

// File: design/lzw_variable_width_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// LZW decoder with 9 to 12 bit codes packed LSB first. Every request (feed a
// compressed byte, pull one decoded byte, start a new stream) returns exactly
// one item. A front stage classifies requests into a two-entry command queue,
// and the back engine executes them one at a time. In the back engine a start,
// a rejected request or a feed that completes no code steps through accept and
// respond; a feed that completes a clear, an end or the first code after a
// clear steps through accept, decode and respond; a pull steps through accept,
// the registered stack read and the pop. A feed that completes any other code
// steps through accept, decode, table read, last push, dictionary update and
// respond, plus a walk step and a registered read of the prefix and suffix
// tables for every byte the chain walk pushes before the last one. The engine
// takes a new command only while the result register is free or being
// emptied, so a held result stalls it. A start clears the tables by resetting a
// high-water mark of written dictionary slots, so no clearing pass follows reset.
module lzw_variable_width_decoder import lzw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);
   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   // The front stage decouples the requester from the decode engine.
   lzw_front u_front (
      .clock, .reset, .push, .full, .req_data,
      .cmd_valid, .cmd_data, .cmd_take
   );

   // The back engine owns all dictionary and stack state.
   lzw_back u_back (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_take,
      .empty, .pop, .rsp_data
   );
endmodule
`default_nettype wire
